[hw/rtl/bsti_pkg.sv]
// shared types and constants for the bounded sorted top-k insertion block
package bsti_pkg;

	localparam int MAX_NB = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic REG_K_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ACK,
		BK_READ
	} bk_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [30:0] distance;
		logic [31:0] tbl_id;
		logic [31:0] set_id;
		logic [31:0] vector_pos;
		logic [31:0] query_pos;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic        accepted;
		logic [5:0]  fill;
		logic [4:0]  rank;
		logic [30:0] entry_distance;
		logic [31:0] entry_table;
		logic [31:0] entry_set;
		logic [31:0] entry_pos;
		logic [31:0] entry_query;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [30:0] distance;
		logic [31:0] tbl;
		logic [31:0] set_id;
		logic [31:0] pos;
		logic [31:0] qry;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t ent;
	} cmd_t;

endpackage

[hw/rtl/bounded_sorted_topk_insert.sv]
// top level of the bounded sorted top-k insertion block
//
// keeps up to k nearest candidates sorted by ascending distance
// input channel: in_valid/in_ready with one in_word_t per word; action
// selects insert, read out or clear, other codes only acknowledge
// output channel: out_valid/out_ready with one out_word_t per word
// insert, clear, unused codes and a read out of an empty list give one
// acknowledgement word; otherwise read out gives one word per held entry
// in rank order, last set on the final one; the first output word passes
// the front register, the queue and the execute step in the cell row into
// the output register, then further read out words follow one per cycle
// while the receiver takes them; the back sequencer takes a new command
// only when idle, after the acknowledgement or the last read out word
// while the back part waits, the front takes words until the queue is full
// a stalled receiver holds the output register and the sequencer waits
// reset empties the list and sets k_in_use to 32; k_in_use at byte address
// 0 of the APB port, 0 acts as 1 and values above 32 act as 32
module bounded_sorted_topk_insert import bsti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0] k_q;
	logic [5:0] k_eff;
	logic       fq_valid;
	logic       fq_ready;
	cmd_t       fq_cmd;
	logic       qb_valid;
	logic       qb_ready;
	cmd_t       qb_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_K_IN_USE) ? {26'd0, k_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 6'(MAX_NB);
		end else if (psel && penable && pwrite && paddr[2] == REG_K_IN_USE) begin
			k_q <= pwdata[5:0];
		end
	end

	assign k_eff = (k_q == '0) ? 6'd1 : ((k_q > 6'(MAX_NB)) ? 6'(MAX_NB) : k_q);

	bsti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	bsti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_cmd)
	);

	bsti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.k_eff     (k_eff),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/bsti_front.sv]
// input stage: accepts words and decodes the action into an operation
module bsti_front import bsti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_dec;

	always_comb begin
		unique case (in_data.action)
			ACT_INSERT: op_dec = OP_INSERT;
			ACT_READ:   op_dec = OP_READ;
			ACT_CLEAR:  op_dec = OP_CLEAR;
			default:    op_dec = OP_NOP;
		endcase
	end

	assign in_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op <= op_dec;
			cmd_s1.ent.distance <= in_data.distance;
			cmd_s1.ent.tbl <= in_data.tbl_id;
			cmd_s1.ent.set_id <= in_data.set_id;
			cmd_s1.ent.pos <= in_data.vector_pos;
			cmd_s1.ent.qry <= in_data.query_pos;
		end
	end

endmodule

[hw/rtl/bsti_queue.sv]
// short command queue between the front and back parts
module bsti_queue import bsti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/bsti_back.sv]
// back part: sorted row of entry cells, sequencer and output register
module bsti_back import bsti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic [5:0] k_eff,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data
);

	entry_t      cell_q [MAX_NB];
	logic [5:0]  fill_q;
	bk_state_t   state_q;
	bk_state_t   state_d;
	logic [4:0]  rd_idx_q;
	logic        acc_q;
	logic        out_valid_q;
	out_word_t   out_q;
	out_word_t   out_d;

	logic [5:0]        fill_eff;
	logic              full;
	logic [4:0]        k_last;
	logic [4:0]        ins_pos;
	logic [MAX_NB-1:0] gt;
	logic [MAX_NB-1:0] gtm;
	logic              acc;
	logic              exec;
	logic              do_ins;
	logic              ld_out;
	logic              out_free;
	logic [4:0]        rd_addr;
	entry_t            rd_ent;
	logic              rd_last;
	logic [30:0]       worst;

	assign fill_eff = (fill_q > k_eff) ? k_eff : fill_q;
	assign full = fill_eff == k_eff;
	assign k_last = 5'(k_eff - 6'd1);
	assign ins_pos = full ? k_last : fill_eff[4:0];

	for (genvar i = 0; i < MAX_NB; i++) begin : g_cmp
		assign gt[i] = cell_q[i].distance > cmd.ent.distance;
		assign gtm[i] = gt[i] && (5'(i) < ins_pos);
	end

	assign acc = !full || gt[k_last];
	assign exec = cmd_valid && cmd_ready;
	assign do_ins = exec && cmd.op == OP_INSERT && acc;
	assign out_free = !out_valid_q || out_ready;

	assign rd_addr = (state_q == BK_READ) ? rd_idx_q : 5'(fill_q - 6'd1);
	assign rd_ent = cell_q[rd_addr];
	assign rd_last = ({1'b0, rd_idx_q} + 6'd1) == fill_q;
	assign worst = (fill_q == '0) ? '0 : rd_ent.distance;

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		ld_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd.op == OP_READ && fill_eff != '0) begin
						state_d = BK_READ;
					end else begin
						state_d = BK_ACK;
					end
				end
			end
			BK_ACK: begin
				if (out_free) begin
					ld_out = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				if (out_free) begin
					ld_out = 1'b1;
					if (rd_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		out_d.kind = state_q == BK_READ;
		out_d.accepted = (state_q == BK_ACK) && acc_q;
		out_d.fill = fill_q;
		if (state_q == BK_READ) begin
			out_d.rank = rd_idx_q;
			out_d.entry_distance = rd_ent.distance;
			out_d.entry_table = rd_ent.tbl;
			out_d.entry_set = rd_ent.set_id;
			out_d.entry_pos = rd_ent.pos;
			out_d.entry_query = rd_ent.qry;
			out_d.last = rd_last;
		end else begin
			out_d.rank = '0;
			out_d.entry_distance = worst;
			out_d.entry_table = '0;
			out_d.entry_set = '0;
			out_d.entry_pos = '0;
			out_d.entry_query = '0;
			out_d.last = 1'b1;
		end
	end

	// each cell takes its left neighbour, the new candidate, or holds
	for (genvar i = 0; i < MAX_NB; i++) begin : g_cell
		logic shift_in;
		if (i == 0) begin : g_first
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign shift_in = gtm[i-1];
		end
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (shift_in) begin
					cell_q[i] <= cell_q[(i == 0) ? 0 : i - 1];
				end else if (gtm[i] || 5'(i) == ins_pos) begin
					cell_q[i] <= cmd.ent;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q <= '0;
			rd_idx_q <= '0;
			acc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				rd_idx_q <= '0;
				acc_q <= cmd.op == OP_INSERT && acc;
				unique case (cmd.op)
					OP_INSERT: fill_q <= (acc && !full) ? fill_eff + 6'd1 : fill_eff;
					OP_CLEAR:  fill_q <= '0;
					default:   fill_q <= fill_eff;
				endcase
			end else begin
				fill_q <= fill_eff;
				if (ld_out && state_q == BK_READ) begin
					rd_idx_q <= rd_idx_q + 5'd1;
				end
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[dv/tb.sv]
// testbench for bounded_sorted_topk_insert: directed table then random phases against a predictor
module tb;
	import bsti_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int WATCH_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 60;
	localparam int ITEM_TARGET = 310;
	localparam int NUM_ROWS = 21;

	typedef struct packed {
		logic       set_k;
		logic [5:0] k;
		in_word_t   w;
		logic       typed;
		out_word_t  x;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	entry_t      nb_list [MAX_NB];
	int          nb_fill;
	logic [5:0]  k_reg;
	out_word_t   due_words [$];
	out_word_t   step_words [$];
	int          mismatches;
	int          sent_items;
	int          quiet_cycles;
	bit          steady;
	plan_row_t   plan_rows [NUM_ROWS];
	int          k_plan [10] = '{32, 3, 0, 63, 1, 24, 33, 2, 32, 7};

	bounded_sorted_topk_insert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic in_word_t cand(logic [1:0] a, logic [30:0] d, logic [31:0] t,
			logic [31:0] s, logic [31:0] v, logic [31:0] q);
		return '{a, d, t, s, v, q};
	endfunction

	function automatic out_word_t ack_word(logic acc, logic [5:0] f, logic [30:0] d);
		return '{1'b0, acc, f, 5'd0, d, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
	endfunction

	function automatic int k_eff();
		int k;
		k = k_reg;
		if (k == 0) k = 1;
		if (k > MAX_NB) k = MAX_NB;
		return k;
	endfunction

	function automatic logic [30:0] worst_dist();
		if (nb_fill > 0) return nb_list[nb_fill - 1].distance;
		return '0;
	endfunction

	// expected words for one accepted input word, updates the list
	function automatic void step_list(in_word_t w);
		int k;
		int p;
		logic acc;
		entry_t e;
		k = k_eff();
		if (nb_fill > k) nb_fill = k;
		e = '{w.distance, w.tbl_id, w.set_id, w.vector_pos, w.query_pos};
		step_words.delete();
		case (w.action)
			ACT_INSERT: begin
				acc = 1'b0;
				p = -1;
				if (nb_fill < k) begin
					p = nb_fill;
					nb_fill++;
				end else if (w.distance < nb_list[k - 1].distance) begin
					p = k - 1;
				end
				if (p >= 0) begin
					while (p > 0 && nb_list[p - 1].distance > e.distance) begin
						nb_list[p] = nb_list[p - 1];
						p--;
					end
					nb_list[p] = e;
					acc = 1'b1;
				end
				step_words.push_back(ack_word(acc, 6'(nb_fill), worst_dist()));
			end
			ACT_CLEAR: begin
				nb_fill = 0;
				step_words.push_back(ack_word(1'b0, 6'd0, 31'd0));
			end
			ACT_READ: begin
				if (nb_fill == 0) begin
					step_words.push_back(ack_word(1'b0, 6'd0, 31'd0));
				end else begin
					for (int i = 0; i < nb_fill; i++) begin
						step_words.push_back('{1'b1, 1'b0, 6'(nb_fill), 5'(i),
							nb_list[i].distance, nb_list[i].tbl, nb_list[i].set_id,
							nb_list[i].pos, nb_list[i].qry, 1'(i == nb_fill - 1)});
					end
				end
			end
			default: begin
				step_words.push_back(ack_word(1'b0, 6'(nb_fill), worst_dist()));
			end
		endcase
	endfunction

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_word(out_word_t got);
		out_word_t want;
		if (due_words.size() == 0) begin
			$error("unexpected word: kind %0d rank %0d", got.kind, got.rank);
			mismatches++;
			return;
		end
		want = due_words.pop_front();
		match_field("kind", want.kind, got.kind);
		match_field("accepted", want.accepted, got.accepted);
		match_field("fill", want.fill, got.fill);
		match_field("rank", want.rank, got.rank);
		match_field("entry_distance", want.entry_distance, got.entry_distance);
		match_field("entry_table", want.entry_table, got.entry_table);
		match_field("entry_set", want.entry_set, got.entry_set);
		match_field("entry_pos", want.entry_pos, got.entry_pos);
		match_field("entry_query", want.entry_query, got.entry_query);
		match_field("last", want.last, got.last);
	endfunction

	function automatic in_word_t rand_item();
		int r;
		int s;
		logic [1:0] a;
		logic [30:0] d;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 9);
		if (r < 76) a = ACT_INSERT;
		else if (r < 86) a = ACT_READ;
		else if (r < 91) a = ACT_CLEAR;
		else a = ACT_UNUSED;
		case (s)
			0: d = 31'd0;
			1: d = 31'h7FFFFFFF;
			2, 3, 4: d = 31'($urandom_range(0, 7));
			5, 6: d = 31'h3F800000 + 31'($urandom_range(0, 255));
			default: d = 31'($urandom());
		endcase
		return cand(a, d, $urandom(), $urandom(), $urandom(), $urandom());
	endfunction

	task automatic write_k(logic [5:0] k);
		int k_now;
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_K_IN_USE);
		pwdata <= {26'd0, k};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		k_reg = k;
		k_now = k_eff();
		if (nb_fill > k_now) nb_fill = k_now;
	endtask

	task automatic send_word(in_word_t w, logic typed, out_word_t typed_word);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		step_list(w);
		if (typed) due_words.push_back(typed_word);
		else foreach (step_words[i]) due_words.push_back(step_words[i]);
		sent_items++;
	endtask

	initial begin
		int n;
		int ph;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		sent_items = 0;
		nb_fill = 0;
		k_reg = 6'd32;
		for (int i = 0; i < MAX_NB; i++) nb_list[i] = '0;
		plan_rows = '{
			'{1'b0, 6'd0, cand(ACT_READ, 31'd0, 0, 0, 0, 0), 1'b1, ack_word(1'b0, 6'd0, 31'd0)},
			'{1'b0, 6'd0, cand(ACT_CLEAR, 31'd0, 0, 0, 0, 0), 1'b1, ack_word(1'b0, 6'd0, 31'd0)},
			'{1'b0, 6'd0, cand(ACT_UNUSED, 31'd0, 0, 0, 0, 0), 1'b1, ack_word(1'b0, 6'd0, 31'd0)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'h7FFFFFFF, '1, '1, '1, '1), 1'b1,
				ack_word(1'b1, 6'd1, 31'h7FFFFFFF)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'd0, 0, 0, 0, 0), 1'b1,
				ack_word(1'b1, 6'd2, 31'h7FFFFFFF)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'h3F800000, 1, 2, 3, 4), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'h3F800000, 5, 6, 7, 8), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_READ, 31'd0, 0, 0, 0, 0), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_UNUSED, 31'h2AAAAAAA, 32'h55555555, 32'hAAAAAAAA,
				32'h55555555, 32'hAAAAAAAA), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_CLEAR, 31'h7FFFFFFF, '1, '1, '1, '1), 1'b1,
				ack_word(1'b0, 6'd0, 31'd0)},
			'{1'b1, 6'd1, cand(ACT_INSERT, 31'd5, 11, 12, 13, 14), 1'b1,
				ack_word(1'b1, 6'd1, 31'd5)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'd5, 21, 22, 23, 24), 1'b1,
				ack_word(1'b0, 6'd1, 31'd5)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'd4, 31, 32, 33, 34), 1'b1,
				ack_word(1'b1, 6'd1, 31'd4)},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'h7FFFFFFF, 41, 42, 43, 44), 1'b1,
				ack_word(1'b0, 6'd1, 31'd4)},
			'{1'b0, 6'd0, cand(ACT_READ, 31'd0, 0, 0, 0, 0), 1'b0, '0},
			'{1'b1, 6'd63, cand(ACT_INSERT, 31'h10, 51, 52, 53, 54), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'h10, 61, 62, 63, 64), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_READ, 31'd0, 0, 0, 0, 0), 1'b0, '0},
			'{1'b1, 6'd0, cand(ACT_READ, 31'd0, 0, 0, 0, 0), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_INSERT, 31'd0, 71, 72, 73, 74), 1'b0, '0},
			'{1'b0, 6'd0, cand(ACT_CLEAR, 31'd0, 0, 0, 0, 0), 1'b1, ack_word(1'b0, 6'd0, 31'd0)}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan_rows[i]) begin
			if (plan_rows[i].set_k) write_k(plan_rows[i].k);
			send_word(plan_rows[i].w, plan_rows[i].typed, plan_rows[i].x);
		end
		ph = 0;
		while (sent_items < ITEM_TARGET) begin
			write_k(ph < 10 ? 6'(k_plan[ph]) : 6'($urandom_range(0, 63)));
			steady = ($urandom_range(0, 3) == 0);
			n = $urandom_range(20, 45);
			repeat (n) send_word(rand_item(), 1'b0, '0);
			send_word(cand(ACT_READ, 31'($urandom()), $urandom(), $urandom(), $urandom(),
				$urandom()), 1'b0, '0);
			ph++;
		end
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_word(out_data);
		end
	end

	// cycles with no word moving on either side and no register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCH_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

[bounded_sorted_topk_insert.f]
hw/rtl/bsti_pkg.sv
hw/rtl/bsti_front.sv
hw/rtl/bsti_queue.sv
hw/rtl/bsti_back.sv
hw/rtl/bounded_sorted_topk_insert.sv
dv/tb.sv
